### hdl/smt_pkg.sv
// ----------------------------------------------------------------------------
// smt_pkg
// shared types and constants for the sorted multiset table
// ----------------------------------------------------------------------------
package smt_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int COUNT_W      = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_COUNT  = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INS,
        ST_PUT,
        ST_CNT
    } t_state;

endpackage

### hdl/smt_mem.sv
// ----------------------------------------------------------------------------
// smt_mem
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module smt_mem #(
    parameter int DEPTH = smt_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(smt_pkg::CAPACITY_DEF)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [smt_pkg::VALUE_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [smt_pkg::VALUE_W-1:0] o_rdata
);

    logic [smt_pkg::VALUE_W-1:0] mem [DEPTH];
    logic [smt_pkg::VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/smt_ctrl.sv
// ----------------------------------------------------------------------------
// smt_ctrl
// sequencer: shifts entries up for insert, scans entries for count,
// holds the fill level and the result register
// ----------------------------------------------------------------------------
module smt_ctrl #(
    parameter int CAPACITY = smt_pkg::CAPACITY_DEF,
    parameter int AW       = $clog2(smt_pkg::CAPACITY_DEF),
    parameter int FW       = $clog2(smt_pkg::CAPACITY_DEF + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_op,
    input  logic signed [smt_pkg::VALUE_W-1:0] i_value,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_status,
    output logic [smt_pkg::COUNT_W-1:0] o_match_count,
    output logic                        o_is_empty,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [smt_pkg::VALUE_W-1:0] o_mem_wdata,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [smt_pkg::VALUE_W-1:0] i_mem_rdata
);

    smt_pkg::t_state r_state, n_state;
    logic [FW-1:0] r_fill, n_fill;
    logic [FW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_idx, n_idx;
    logic signed [smt_pkg::VALUE_W-1:0] r_val, n_val;
    logic [smt_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic r_status, n_status;
    logic [smt_pkg::COUNT_W-1:0] r_count, n_count;
    logic r_empty, n_empty;

    logic                        out_free;
    logic [smt_pkg::COUNT_W-1:0] cnt_next;
    logic signed [smt_pkg::VALUE_W-1:0] rd_val;

    assign out_free = !r_out_valid || i_ready;
    assign rd_val   = $signed(i_mem_rdata);
    assign cnt_next = ((i_mem_rdata == r_val) && (r_cnt != smt_pkg::COUNT_MAX))
                    ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= smt_pkg::ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
        r_pos    <= n_pos;
        r_idx    <= n_idx;
        r_val    <= n_val;
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_count  <= n_count;
        r_empty  <= n_empty;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_val       = r_val;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_count     = r_count;
        n_empty     = r_empty;
        o_ready     = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = r_val;
        o_mem_raddr = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            smt_pkg::ST_IDLE: begin
                o_ready = out_free;
                if (i_valid && out_free) begin
                    n_val    = i_value;
                    n_status = 1'b0;
                    n_count  = '0;
                    case (i_op)
                        smt_pkg::OP_INSERT: begin
                            if (r_fill == FW'(CAPACITY)) begin
                                n_out_valid = 1'b1;
                                n_status    = 1'b1;
                                n_empty     = 1'b0;
                            end else if (r_fill == '0) begin
                                o_mem_we    = 1'b1;
                                o_mem_wdata = i_value;
                                n_fill      = FW'(1);
                                n_out_valid = 1'b1;
                                n_empty     = 1'b0;
                            end else begin
                                n_pos       = r_fill;
                                o_mem_raddr = AW'(r_fill - 1'b1);
                                n_state     = smt_pkg::ST_INS;
                            end
                        end
                        smt_pkg::OP_COUNT: begin
                            if (r_fill == '0) begin
                                n_out_valid = 1'b1;
                                n_empty     = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_cnt   = '0;
                                n_state = smt_pkg::ST_CNT;
                            end
                        end
                        smt_pkg::OP_CLEAR: begin
                            n_fill      = '0;
                            n_out_valid = 1'b1;
                            n_empty     = 1'b1;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_empty     = (r_fill == '0);
                        end
                    endcase
                end
            end
            smt_pkg::ST_INS: begin
                // read data is the entry just below the hole at r_pos
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_pos);
                if (rd_val > r_val) begin
                    o_mem_wdata = i_mem_rdata;
                    n_pos       = r_pos - 1'b1;
                    if (r_pos == FW'(1)) begin
                        n_state = smt_pkg::ST_PUT;
                    end else begin
                        o_mem_raddr = AW'(r_pos - FW'(2));
                    end
                end else begin
                    n_fill      = r_fill + 1'b1;
                    n_out_valid = 1'b1;
                    n_empty     = 1'b0;
                    n_state     = smt_pkg::ST_IDLE;
                end
            end
            smt_pkg::ST_PUT: begin
                o_mem_we    = 1'b1;
                n_fill      = r_fill + 1'b1;
                n_out_valid = 1'b1;
                n_empty     = 1'b0;
                n_state     = smt_pkg::ST_IDLE;
            end
            smt_pkg::ST_CNT: begin
                if (FW'(r_idx) == r_fill - 1'b1) begin
                    n_count     = cnt_next;
                    n_out_valid = 1'b1;
                    n_empty     = 1'b0;
                    n_state     = smt_pkg::ST_IDLE;
                end else begin
                    n_cnt       = cnt_next;
                    n_idx       = r_idx + 1'b1;
                    o_mem_raddr = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = smt_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_match_count = r_count;
    assign o_is_empty    = r_empty;

endmodule

### hdl/sorted_multiset_table.sv
// insert: answered straight from idle into an empty or full store, else larger entries shift up first
// count: answered straight from idle on an empty store, else a scan, one entry read a cycle
// clear and the unused code: answered straight from idle; the memory's single read port sets the scan rate
// a new word is taken once the sequencer is idle and the result register is free
// reset clears the fill level and control; entries are not cleared, no clearing pass
// ----------------------------------------------------------------------------
// sorted_multiset_table
// bounded ascending store of signed values with insert, count and clear
// ----------------------------------------------------------------------------
module sorted_multiset_table #(
    parameter int CAPACITY = smt_pkg::CAPACITY_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_op,
    input  logic signed [smt_pkg::VALUE_W-1:0] i_value,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_status,
    output logic [smt_pkg::COUNT_W-1:0]        o_match_count,
    output logic                               o_is_empty
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [smt_pkg::VALUE_W-1:0] mem_wdata;
    logic [AW-1:0]               mem_raddr;
    logic [smt_pkg::VALUE_W-1:0] mem_rdata;

    smt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .FW       (FW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_match_count (o_match_count),
        .o_is_empty    (o_is_empty),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    smt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

### hdl/smt_checker.sv
// ----------------------------------------------------------------------------
// smt_checker
// port-level checks for the sorted multiset table
// ----------------------------------------------------------------------------
module smt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [1:0]                  i_op,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_status,
    input logic [smt_pkg::COUNT_W-1:0] o_match_count,
    input logic                        o_is_empty
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_match_count) && $stable(o_is_empty))
        else $error("result word changed while stalled");

    // a refused insert reports a nonempty store and no matches
    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> !o_is_empty && (o_match_count == '0))
        else $error("refused insert with empty store or nonzero count");

    // matches imply stored entries and no refused insert
    a_match_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_match_count != '0) |-> !o_is_empty && !o_status)
        else $error("matches reported on an empty store");

    // clear answers in the next cycle with an empty store
    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_op == smt_pkg::OP_CLEAR)
            |=> o_valid && o_is_empty && !o_status)
        else $error("clear did not answer with empty store");

endmodule

bind sorted_multiset_table smt_checker u_smt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .i_op          (i_op),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_match_count (o_match_count),
    .o_is_empty    (o_is_empty)
);
